// ----- rtl/core/signed_int_to_decimal_ascii_assert.svh -----
// assertion macros for the signed integer to decimal text block
// used by the top level only, no other dependencies
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`ifndef SYNTHESIS
`define SIDTA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sidta assertion failed");
`define SIDTA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sidta assertion failed");
`else
`define SIDTA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIDTA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/sidta_pkg.sv -----
// shared constants and types for the signed integer to decimal text block
// no dependencies
package sidta_pkg;

    localparam int CHAR_W = 6;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;

    // bcd digit correction before each shift
    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ_ADD = 4'd3;

    localparam int QDEPTH = 2;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- rtl/core/sidta_front.sv -----
// front end: accepts values, splits them into sign and unsigned magnitude
// depends on sidta_pkg
module sidta_front #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_stall,
    input  sidta_pkg::t_q_status          i_qstat,
    output logic                          o_push,
    output logic                          o_neg,
    output logic [VALUE_WIDTH-1:0]        o_mag
);
    import sidta_pkg::*;

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] w_uval;
    logic                   w_accept;

    assign w_uval   = i_value;
    assign o_stall  = r_valid && i_qstat.full;
    assign w_accept = i_valid && !o_stall;
    assign o_push   = r_valid && !i_qstat.full;
    assign o_neg    = r_neg;
    assign o_mag    = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // magnitude as unsigned, so the most negative value needs no extra bit
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_uval[VALUE_WIDTH-1];
            r_mag <= w_uval[VALUE_WIDTH-1] ? (~w_uval + 1'b1) : w_uval;
        end
    end

endmodule

// ----- rtl/core/sidta_queue.sv -----
// short register queue between front and back end
// depends on sidta_pkg
module sidta_queue #(
    parameter int WIDTH = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [WIDTH-1:0]     i_wr_data,
    input  logic                 i_pop,
    output logic [WIDTH-1:0]     o_rd_data,
    output sidta_pkg::t_q_status o_qstat
);
    import sidta_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0] r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_qstat.full  = (r_count == CNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_rd_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- rtl/core/sidta_back.sv -----
// back end: binary to bcd by shift and add-3, then emits sign and digits
// depends on sidta_pkg
module sidta_back #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_pop_valid,
    input  logic                          i_neg,
    input  logic [VALUE_WIDTH-1:0]        i_mag,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [sidta_pkg::CHAR_W-1:0]  o_char_code,
    output logic                          o_last_char
);
    import sidta_pkg::*;

    localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W = NDIG * 4;
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int DL_W  = $clog2(NDIG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_DIGIT
    } t_state;

    t_state                 r_state;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_shift;
    logic [BCD_W-1:0]       r_bcd;
    logic [CNT_W-1:0]       r_cnt;
    logic [DL_W-1:0]        r_dig_left;
    logic                   r_started;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;

    logic [BCD_W-1:0]       w_adj;
    logic [3:0]             w_top;
    logic                   w_out_free;
    logic                   w_skip;
    logic                   w_emit;

    assign o_pop       = (r_state == S_IDLE) && i_pop_valid;
    assign o_valid     = r_out_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;
    assign w_top       = r_bcd[BCD_W-1 -: 4];
    assign w_out_free  = !r_out_valid || !i_stall;
    // leading zeros drop out one per cycle, the units digit always goes
    assign w_skip      = !r_started && (w_top == 4'd0) && (r_dig_left != DL_W'(1));
    assign w_emit      = w_out_free &&
                         ((r_state == S_SIGN) || ((r_state == S_DIGIT) && !w_skip));

    always_comb begin
        for (int d = 0; d < NDIG; d++) begin
            w_adj[d*4 +: 4] = (r_bcd[d*4 +: 4] >= BCD_ADJ_MIN) ?
                              r_bcd[d*4 +: 4] + BCD_ADJ_ADD : r_bcd[d*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_neg   <= i_neg;
                        r_shift <= i_mag;
                        r_bcd   <= '0;
                        r_cnt   <= CNT_W'(VALUE_WIDTH);
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_bcd   <= {w_adj[BCD_W-2:0], r_shift[VALUE_WIDTH-1]};
                    r_shift <= {r_shift[VALUE_WIDTH-2:0], 1'b0};
                    r_cnt   <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_dig_left <= DL_W'(NDIG);
                        r_started  <= 1'b0;
                        r_state    <= r_neg ? S_SIGN : S_DIGIT;
                    end
                end
                S_SIGN: begin
                    if (w_out_free) begin
                        r_char      <= ASCII_MINUS;
                        r_last      <= 1'b0;
                        r_state     <= S_DIGIT;
                    end
                end
                S_DIGIT: begin
                    if (w_skip) begin
                        r_bcd      <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_dig_left <= r_dig_left - 1'b1;
                    end else if (w_out_free) begin
                        r_char      <= ASCII_ZERO + {2'b00, w_top};
                        r_last      <= (r_dig_left == DL_W'(1));
                        r_started   <= 1'b1;
                        r_bcd       <= {r_bcd[BCD_W-5:0], 4'd0};
                        r_dig_left  <= r_dig_left - 1'b1;
                        if (r_dig_left == DL_W'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text, top level.
// Depends on sidta_pkg, sidta_front, sidta_queue, sidta_back and the assert header.
//
// Input channel: i_valid / i_value, with o_stall driven back; a value
// transfers on a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / o_char_code / o_last_char, with i_stall from
// the receiver; one character transfers per edge with o_valid high and
// i_stall low. Characters come most significant first, a minus sign ahead
// of a negative value, and o_last_char marks the final character.
// Each value leaves the queue, then goes through shift-and-add-3
// conversion over its VALUE_WIDTH bits, then a minus sign if negative, then
// each digit position in turn, either skipped as a leading zero or emitted.
// A front register and a two-entry queue take further values while the
// back end converts, so the sender sees stall only once both are full.
// A stalled output character holds its value until it transfers.
// Synchronous active-low reset empties the queue and drops any value in
// flight; the block is ready once reset is released.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_stall,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [5:0]                    o_char_code,
    output logic                          o_last_char
);
    import sidta_pkg::*;

    localparam int Q_W = VALUE_WIDTH + 1;

    t_q_status              w_qstat;
    logic                   w_push;
    logic                   w_front_neg;
    logic [VALUE_WIDTH-1:0] w_front_mag;
    logic                   w_pop;
    logic [Q_W-1:0]         w_rd_data;

    sidta_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_value (i_value),
        .o_stall (o_stall),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_neg   (w_front_neg),
        .o_mag   (w_front_mag)
    );

    sidta_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_wr_data ({w_front_neg, w_front_mag}),
        .i_pop     (w_pop),
        .o_rd_data (w_rd_data),
        .o_qstat   (w_qstat)
    );

    sidta_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (!w_qstat.empty),
        .i_neg       (w_rd_data[Q_W-1]),
        .i_mag       (w_rd_data[VALUE_WIDTH-1:0]),
        .o_pop       (w_pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last_char (o_last_char)
    );

`include "signed_int_to_decimal_ascii_assert.svh"

    // only a minus sign or a decimal digit ever leaves
    `SIDTA_ASSERT_IMP(a_char_legal, i_clk, i_rst_n, o_valid, (o_char_code == ASCII_MINUS) || ((o_char_code >= ASCII_ZERO) && (o_char_code <= ASCII_NINE)))
    // a sign is always followed by digits
    `SIDTA_ASSERT_IMP(a_minus_not_last, i_clk, i_rst_n, o_valid && (o_char_code == ASCII_MINUS), !o_last_char)
    // the front never writes a full queue and the back never reads an empty one
    `SIDTA_ASSERT_IMP(a_queue_safe, i_clk, i_rst_n, w_push || w_pop, !(w_push && w_qstat.full) && !(w_pop && w_qstat.empty))
    // a transferred last character cannot be followed at once by another one
    `SIDTA_ASSERT_NXT(a_gap_after_last, i_clk, i_rst_n, o_valid && !i_stall && o_last_char, !o_valid)

endmodule

// ----- tb/tb_signed_int_to_decimal_ascii.sv -----
// self-checking testbench for signed_int_to_decimal_ascii
// needs only the block's rtl and sidta_pkg; predicts the decimal text of every
// accepted value and checks each character transfer against it in order
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

    import sidta_pkg::*;

    localparam int VALUE_W      = 32;
    localparam int IDLE_PERCENT = 19;
    localparam int RANDOM_ITEMS = 200;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_text_char;

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_valid     = 1'b0;
    logic signed [VALUE_W-1:0] i_value     = '0;
    logic                      i_stall     = 1'b0;
    logic                      o_stall;
    logic                      o_valid;
    logic [5:0]                o_char_code;
    logic                      o_last_char;

    logic signed [VALUE_W-1:0] pending_values[$];
    t_text_char                expected_chars[$];

    int error_count     = 0;
    int values_accepted = 0;
    int negatives_seen  = 0;
    int chars_checked   = 0;

    signed_int_to_decimal_ascii #(
        .VALUE_WIDTH(VALUE_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_value    (i_value),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // no idling on either side for a stretch in the middle of the run
    function automatic bit idle_now();
        if (values_accepted >= 80 && values_accepted < 140)
            return 1'b0;
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    // decimal text of one value: optional minus, then digits, last one flagged
    function automatic void predict_decimal_text(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digits[$];
        t_text_char         ch;
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        do begin
            digits.push_front(4'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        if (v[VALUE_W-1]) begin
            ch.code = ASCII_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        for (int k = 0; k < digits.size(); k++) begin
            ch.code = ASCII_ZERO + CHAR_W'(digits[k]);
            ch.last = (k == digits.size() - 1);
            expected_chars.push_back(ch);
        end
    endfunction

    // mix of full-range words, chosen digit counts and values near the extremes
    function automatic logic [VALUE_W-1:0] random_value();
        int      mode;
        int      nd;
        longint  lo;
        longint  hi;
        longint  mag;
        mode = $urandom_range(0, 9);
        if (mode < 4)
            return $urandom;
        if (mode == 9) begin
            if ($urandom_range(0, 1))
                return 32'h8000_0000 + $urandom_range(0, 20);
            return 32'h7fff_ffff - $urandom_range(0, 20);
        end
        nd = $urandom_range(1, 10);
        lo = (nd == 1) ? 0 : 1;
        for (int k = 1; k < nd; k++)
            lo = lo * 10;
        hi = (nd == 1) ? 9 : lo * 10 - 1;
        if (hi > 64'd2147483647)
            hi = 64'd2147483647;
        mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
        return $urandom_range(0, 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
    endfunction

    // driver: holds a stalled transfer, otherwise takes the next pending value
    always @(posedge i_clk) begin
        logic                      next_valid;
        logic signed [VALUE_W-1:0] next_value;
        next_valid = i_valid;
        next_value = i_value;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                predict_decimal_text(i_value);
                values_accepted++;
                if (i_value[VALUE_W-1])
                    negatives_seen++;
            end
            next_valid = 1'b0;
            if (pending_values.size() != 0 && !idle_now()) begin
                next_valid = 1'b1;
                next_value = pending_values.pop_front();
            end
        end
        i_valid <= next_valid;
        i_value <= next_value;
    end

    // receiver stall, independent of o_valid
    always @(posedge i_clk) begin
        i_stall <= i_rst_n && idle_now();
    end

    // monitor: every character transfer against the oldest expected one
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character code %0d last %0b",
                         $time, o_char_code, o_last_char);
                error_count++;
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_char_code !== want.code) begin
                    $display("%0t: char_code expected %0d actual %0d",
                             $time, want.code, o_char_code);
                    error_count++;
                end
                if (o_last_char !== want.last) begin
                    $display("%0t: last_char expected %0b actual %0b",
                             $time, want.last, o_last_char);
                    error_count++;
                end
            end
        end
    end

    initial begin
        logic signed [VALUE_W-1:0] directed[$];
        directed = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 2147483647,
                     -2147483648, -2147483647, 2147483646, 1000000000,
                     -1000000000, 999999999, -999999999, 1234567890,
                     -987654321, 32'sh5555_5555, 32'shAAAA_AAAA, 4294967,
                     -80706050};
        foreach (directed[k])
            pending_values.push_back(directed[k]);
        for (int k = 0; k < RANDOM_ITEMS; k++)
            pending_values.push_back(random_value());

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_values.size() != 0 || i_valid)
            @(posedge i_clk);
        while (expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("converted %0d values (%0d negative), checked %0d characters",
                 values_accepted, negatives_seen, chars_checked);
        if (expected_chars.size() != 0) begin
            $display("%0t: %0d expected characters never arrived",
                     $time, expected_chars.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb_signed_int_to_decimal_ascii: done, clean");
        else
            $display("tb_signed_int_to_decimal_ascii: done, errors");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("tb_signed_int_to_decimal_ascii: done, errors");
        $finish;
    end

endmodule
